// ----- hdl/tccs_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Text console package
// Shared constants, command and result types, and back-end state encoding
// for the text console with cursor and scroll.
// ----------------------------------------------------------------------------
package tccs_pkg;

    // Widths of the item fields as they appear on the ports.
    localparam int CHAR_W      = 8;
    localparam int COLOR_W     = 8;
    localparam int CELL_W      = 16;
    localparam int ROW_FIELD_W = 5;
    localparam int COL_FIELD_W = 7;

    // Character and attribute codes.
    localparam logic [CHAR_W-1:0]  NEWLINE_CODE = 8'd10;
    localparam logic [CHAR_W-1:0]  BLANK_CODE   = 8'h20;
    localparam logic [COLOR_W-1:0] RESET_COLOR  = 8'h07;

    // Request type codes.
    localparam logic REQ_PUT  = 1'b0;
    localparam logic REQ_READ = 1'b1;

    // Depth of the command queue between front and back.
    localparam int CMDQ_DEPTH = 2;

    // Classified command kinds.
    typedef enum logic [1:0] {
        CMD_PUT,
        CMD_NEWLINE,
        CMD_READ,
        CMD_READ_OOR
    } t_cmd_kind;

    // One classified command as it travels through the queue.
    typedef struct packed {
        t_cmd_kind               kind;
        logic [CHAR_W-1:0]       char_code;
        logic [ROW_FIELD_W-1:0]  row;
        logic [COL_FIELD_W-1:0]  col;
    } t_cmd;

    // One result item.
    typedef struct packed {
        logic [CELL_W-1:0]       cell_data;
        logic [ROW_FIELD_W-1:0]  cursor_row;
        logic [COL_FIELD_W-1:0]  cursor_column;
    } t_result;

    // Back-end sequencer states.
    typedef enum logic {
        BK_IDLE,
        BK_RDATA
    } t_back_state;

endpackage
`default_nettype wire

// ----- hdl/tccs_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tccs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ----- hdl/tccs_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Text console front end
// Accepts request beats, classifies them into commands and holds each one
// in a register until the command queue takes it.
// ----------------------------------------------------------------------------
module tccs_front #(
    parameter int ROWS    = 25,
    parameter int COLUMNS = 80
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_push,
    input  wire logic                                 i_req_type,
    input  wire logic [tccs_pkg::CHAR_W-1:0]          i_char_code,
    input  wire logic [tccs_pkg::ROW_FIELD_W-1:0]     i_read_row,
    input  wire logic [tccs_pkg::COL_FIELD_W-1:0]     i_read_column,
    output logic                                      o_full,
    input  wire logic                                 i_q_full,
    output logic                                      o_cmd_valid,
    output tccs_pkg::t_cmd                            o_cmd
);
    import tccs_pkg::*;

    logic r_valid;
    logic n_valid;
    t_cmd r_cmd;
    t_cmd n_cmd;
    logic accept;
    logic in_range;

    // The stage is full only while its command cannot move on.
    assign o_full = r_valid && i_q_full;
    assign accept = i_push && !o_full;

    // Classify the incoming request.
    always_comb begin
        in_range = (32'(i_read_row) < ROWS) && (32'(i_read_column) < COLUMNS);
        n_cmd           = r_cmd;
        n_valid         = r_valid && i_q_full;
        if (accept) begin
            n_valid         = 1'b1;
            n_cmd.char_code = i_char_code;
            n_cmd.row       = i_read_row;
            n_cmd.col       = i_read_column;
            if (i_req_type == REQ_READ) begin
                n_cmd.kind = in_range ? CMD_READ : CMD_READ_OOR;
            end else if (i_char_code == NEWLINE_CODE) begin
                n_cmd.kind = CMD_NEWLINE;
            end else begin
                n_cmd.kind = CMD_PUT;
            end
        end
    end

    // Stage valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Stage payload.
    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
    end

    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

endmodule
`default_nettype wire

// ----- hdl/tccs_cmd_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Text console command queue
// Short first-in first-out queue of classified commands between the front
// end and the back end.
// ----------------------------------------------------------------------------
module tccs_cmd_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire tccs_pkg::t_cmd i_cmd,
    output logic                o_full,
    input  wire logic           i_pop,
    output logic                o_empty,
    output tccs_pkg::t_cmd      o_cmd
);
    import tccs_pkg::*;

    localparam int PW = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
    localparam int NW = $clog2(CMDQ_DEPTH + 1);

    t_cmd          r_mem [CMDQ_DEPTH];
    logic [PW-1:0] r_wptr;
    logic [PW-1:0] r_rptr;
    logic [NW-1:0] r_count;
    logic [PW-1:0] n_wptr;
    logic [PW-1:0] n_rptr;
    logic [NW-1:0] n_count;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_count == NW'(CMDQ_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_cmd   = r_mem[r_rptr];

    // Pointer and count update.
    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (do_push) begin
            n_wptr = (r_wptr == PW'(CMDQ_DEPTH - 1)) ? '0 : r_wptr + PW'(1);
        end
        if (do_pop) begin
            n_rptr = (r_rptr == PW'(CMDQ_DEPTH - 1)) ? '0 : r_rptr + PW'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + NW'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - NW'(1);
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

endmodule
`default_nettype wire

// ----- hdl/tccs_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Text console back end
// Executes commands against the screen RAM, keeps the cursor and the
// circular row mapping, and holds one result for the output side.
// ----------------------------------------------------------------------------
module tccs_back #(
    parameter int ROWS    = 25,
    parameter int COLUMNS = 80
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic [tccs_pkg::COLOR_W-1:0]    i_text_color,
    input  wire logic                            i_q_empty,
    input  wire tccs_pkg::t_cmd                  i_cmd,
    output logic                                 o_q_pop,
    input  wire logic                            i_pop,
    output logic                                 o_res_valid,
    output tccs_pkg::t_result                    o_res
);
    import tccs_pkg::*;

    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLUMNS);
    localparam int FW    = $clog2(COLUMNS + 1);
    localparam int DEPTH = ROWS * COLUMNS;
    localparam int AW    = $clog2(DEPTH);

    t_back_state        r_state;
    t_back_state        n_state;
    logic [RW-1:0]      r_row;
    logic [RW-1:0]      n_row;
    logic [CW-1:0]      r_col;
    logic [CW-1:0]      n_col;
    logic [RW-1:0]      r_top;
    logic [RW-1:0]      n_top;
    logic [FW-1:0]      r_fill_cnt   [ROWS];
    logic [FW-1:0]      n_fill_cnt   [ROWS];
    logic [COLOR_W-1:0] r_fill_color [ROWS];
    logic [COLOR_W-1:0] n_fill_color [ROWS];
    logic               r_hit;
    logic               n_hit;
    logic [COLOR_W-1:0] r_miss_color;
    logic [COLOR_W-1:0] n_miss_color;
    logic               r_res_valid;
    logic               n_res_valid;
    t_result            r_res;
    t_result            n_res;

    logic               take;
    logic               wrap;
    logic [RW:0]        cur_sum;
    logic [RW:0]        rd_sum;
    logic [RW-1:0]      cur_phys;
    logic [RW-1:0]      rd_phys;
    logic [RW-1:0]      rd_row;
    logic [CW-1:0]      rd_col;
    logic [AW-1:0]      cur_addr;
    logic [AW-1:0]      rd_addr;
    logic               ram_we;
    logic               ram_re;
    logic [CELL_W-1:0]  ram_q;

    // A command is taken only when the result slot is free.
    assign take    = (r_state == BK_IDLE) && !i_q_empty && !r_res_valid;
    assign o_q_pop = take;

    // Logical row to physical row through the circular top-row pointer.
    always_comb begin
        rd_row   = RW'(i_cmd.row);
        rd_col   = CW'(i_cmd.col);
        cur_sum  = {1'b0, r_top} + {1'b0, r_row};
        rd_sum   = {1'b0, r_top} + {1'b0, rd_row};
        cur_phys = (cur_sum >= (RW+1)'(ROWS)) ? RW'(cur_sum - (RW+1)'(ROWS)) : RW'(cur_sum);
        rd_phys  = (rd_sum >= (RW+1)'(ROWS)) ? RW'(rd_sum - (RW+1)'(ROWS)) : RW'(rd_sum);
        cur_addr = AW'(cur_phys) * AW'(COLUMNS) + AW'(r_col);
        rd_addr  = AW'(rd_phys) * AW'(COLUMNS) + AW'(rd_col);
    end

    // Screen cell storage.
    tccs_ram #(
        .WIDTH (CELL_W),
        .DEPTH (DEPTH)
    ) u_screen_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (cur_addr),
        .i_wdata ({i_text_color, i_cmd.char_code}),
        .i_re    (ram_re),
        .i_raddr (rd_addr),
        .o_rdata (ram_q)
    );

    // Next state of the sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: begin
                if (take && (i_cmd.kind == CMD_READ)) begin
                    n_state = BK_RDATA;
                end
            end
            BK_RDATA: begin
                n_state = BK_IDLE;
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    // Command execution, cursor movement, scrolling and result capture.
    // A scroll rotates the top-row pointer; the row that falls off the top
    // becomes the new bottom row, marked empty and given the current colour.
    always_comb begin
        n_row        = r_row;
        n_col        = r_col;
        n_top        = r_top;
        n_fill_cnt   = r_fill_cnt;
        n_fill_color = r_fill_color;
        n_hit        = r_hit;
        n_miss_color = r_miss_color;
        n_res        = r_res;
        n_res_valid  = r_res_valid && !i_pop;
        ram_we       = 1'b0;
        ram_re       = 1'b0;
        wrap         = 1'b0;
        case (r_state)
            BK_IDLE: begin
                if (take) begin
                    case (i_cmd.kind)
                        CMD_PUT: begin
                            ram_we               = 1'b1;
                            n_fill_cnt[cur_phys] = FW'(r_col) + FW'(1);
                            if (r_col == CW'(COLUMNS - 1)) begin
                                wrap = 1'b1;
                            end else begin
                                n_col = r_col + CW'(1);
                            end
                        end
                        CMD_NEWLINE: begin
                            wrap = 1'b1;
                        end
                        CMD_READ: begin
                            ram_re       = 1'b1;
                            n_hit        = FW'(rd_col) < r_fill_cnt[rd_phys];
                            n_miss_color = r_fill_color[rd_phys];
                        end
                        default: begin
                        end
                    endcase

                    // Step to the start of the next row, scrolling at the bottom.
                    if (wrap) begin
                        n_col = '0;
                        if (r_row == RW'(ROWS - 1)) begin
                            n_fill_cnt[r_top]   = '0;
                            n_fill_color[r_top] = i_text_color;
                            n_top = (r_top == RW'(ROWS - 1)) ? '0 : r_top + RW'(1);
                        end else begin
                            n_row = r_row + RW'(1);
                        end
                    end

                    // Everything but an in-range read finishes in this cycle.
                    if (i_cmd.kind != CMD_READ) begin
                        n_res_valid         = 1'b1;
                        n_res.cell_data     = '0;
                        n_res.cursor_row    = ROW_FIELD_W'(n_row);
                        n_res.cursor_column = COL_FIELD_W'(n_col);
                    end
                end
            end
            BK_RDATA: begin
                n_res_valid         = 1'b1;
                n_res.cell_data     = r_hit ? ram_q : {r_miss_color, BLANK_CODE};
                n_res.cursor_row    = ROW_FIELD_W'(r_row);
                n_res.cursor_column = COL_FIELD_W'(r_col);
            end
            default: begin
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= BK_IDLE;
            r_row        <= '0;
            r_col        <= '0;
            r_top        <= '0;
            r_fill_cnt   <= '{default: '0};
            r_fill_color <= '{default: RESET_COLOR};
            r_res_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_row        <= n_row;
            r_col        <= n_col;
            r_top        <= n_top;
            r_fill_cnt   <= n_fill_cnt;
            r_fill_color <= n_fill_color;
            r_res_valid  <= n_res_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_hit        <= n_hit;
        r_miss_color <= n_miss_color;
        r_res        <= n_res;
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule
`default_nettype wire

// ----- hdl/text_console_cursor_scroll.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Text console with cursor and scroll
// Top level: request front end, command queue and execution back end.
// ----------------------------------------------------------------------------
// Usage:
// Requests enter as a queue: a beat is taken on a clock edge with push high
// and full low. Results leave as a queue: while empty is low the oldest
// result is on the result ports and a beat leaves on an edge with pop high.
// Each request gives exactly one result. The colour register is written over
// its own channel (i_cfg_valid with o_cfg_ready, always ready); the user
// must write it only while idle, as the block itself does not enforce that.
// A put, newline or out-of-range read result passes through the front stage
// register, the command queue and the back end's result register; an
// in-range read also passes the screen RAM's registered read port. The back
// end takes a new command only once its result slot is empty and no read is
// in progress. A scroll needs no extra step: rows sit in the RAM behind a
// rotating top-row pointer and a per-row fill count, so the new bottom row is
// blanked by clearing its count. Reset is synchronous and needs no clearing
// pass: every row reads as blanks in colour 0x07 straight after it. When the
// receiver stalls, the held result blocks the back end while the queue and
// front stage take up to three more requests before full rises.
// ----------------------------------------------------------------------------
module text_console_cursor_scroll #(
    parameter int ROWS    = 25,
    parameter int COLUMNS = 80
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               push,
    output logic                                    full,
    input  wire logic                               i_req_type,
    input  wire logic [tccs_pkg::CHAR_W-1:0]        i_char_code,
    input  wire logic [tccs_pkg::ROW_FIELD_W-1:0]   i_read_row,
    input  wire logic [tccs_pkg::COL_FIELD_W-1:0]   i_read_column,
    output logic                                    empty,
    input  wire logic                               pop,
    output logic      [tccs_pkg::CELL_W-1:0]        o_cell_data,
    output logic      [tccs_pkg::ROW_FIELD_W-1:0]   o_cursor_row,
    output logic      [tccs_pkg::COL_FIELD_W-1:0]   o_cursor_column,
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [tccs_pkg::COLOR_W-1:0]       i_cfg_data
);
    import tccs_pkg::*;

    logic [COLOR_W-1:0] r_text_color;
    logic               fe_valid;
    t_cmd               fe_cmd;
    logic               q_full;
    logic               q_empty;
    logic               q_pop;
    t_cmd               q_cmd;
    logic               res_valid;
    t_result            res;

    // Colour register, written by a configuration beat.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_color <= RESET_COLOR;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_text_color <= i_cfg_data;
        end
    end

    // Request acceptance and classification.
    tccs_front #(
        .ROWS    (ROWS),
        .COLUMNS (COLUMNS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .i_req_type    (i_req_type),
        .i_char_code   (i_char_code),
        .i_read_row    (i_read_row),
        .i_read_column (i_read_column),
        .o_full        (full),
        .i_q_full      (q_full),
        .o_cmd_valid   (fe_valid),
        .o_cmd         (fe_cmd)
    );

    // Command queue between the two halves.
    tccs_cmd_queue u_cmd_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fe_valid),
        .i_cmd   (fe_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_cmd   (q_cmd)
    );

    // Command execution and result slot.
    tccs_back #(
        .ROWS    (ROWS),
        .COLUMNS (COLUMNS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_text_color (r_text_color),
        .i_q_empty    (q_empty),
        .i_cmd        (q_cmd),
        .o_q_pop      (q_pop),
        .i_pop        (pop),
        .o_res_valid  (res_valid),
        .o_res        (res)
    );

    // Result ports.
    assign empty           = !res_valid;
    assign o_cell_data     = res.cell_data;
    assign o_cursor_row    = res.cursor_row;
    assign o_cursor_column = res.cursor_column;

`ifndef SYNTHESIS
    // A reported cursor always lies on the screen.
    a_cursor_on_screen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> ((32'(o_cursor_row) < ROWS) && (32'(o_cursor_column) < COLUMNS)))
        else $error("cursor reported outside the screen");

    // A command handed from the front stage lands in the queue.
    a_handoff_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fe_valid && !q_full) |=> !q_empty)
        else $error("command handed to the queue was lost");

    // The front stage only refuses requests while the queue is full.
    a_full_means_backed_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full |-> (q_full && fe_valid))
        else $error("front stage full while the queue has room");
`endif

endmodule
`default_nettype wire

// ----- tb/tb_console_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Text console checker
// Watches the request, result and colour channels of the text console and
// keeps its own copy of the screen, cursor and colour. Each request beat
// gives one predicted result. Each result beat is compared field by field
// with the oldest prediction, and mismatches are counted.
// ----------------------------------------------------------------------------
module tb_console_checker #(
    parameter int ROWS    = 25,
    parameter int COLUMNS = 80
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_push,
    input  wire logic                               i_full,
    input  wire logic                               i_req_type,
    input  wire logic [tccs_pkg::CHAR_W-1:0]        i_char_code,
    input  wire logic [tccs_pkg::ROW_FIELD_W-1:0]   i_read_row,
    input  wire logic [tccs_pkg::COL_FIELD_W-1:0]   i_read_column,
    input  wire logic                               i_empty,
    input  wire logic                               i_pop,
    input  wire logic [tccs_pkg::CELL_W-1:0]        i_cell_data,
    input  wire logic [tccs_pkg::ROW_FIELD_W-1:0]   i_cursor_row,
    input  wire logic [tccs_pkg::COL_FIELD_W-1:0]   i_cursor_column,
    input  wire logic                               i_cfg_valid,
    input  wire logic                               i_cfg_ready,
    input  wire logic [tccs_pkg::COLOR_W-1:0]       i_cfg_data,
    output int                                      o_errors,
    output int                                      o_pending
);
    import tccs_pkg::*;

    localparam int CELLS = ROWS * COLUMNS;

    // Shadow copy of the console state.
    logic [CELL_W-1:0]  screen_shadow [CELLS];
    int                 row_pos;
    int                 col_pos;
    logic [COLOR_W-1:0] text_attr;

    // Results predicted but not yet seen on the result side.
    t_result console_results_q [$];
    int      error_count   = 0;
    int      pending_count = 0;

    assign o_errors  = error_count;
    assign o_pending = pending_count;

    function automatic logic [CELL_W-1:0] pack_cell(logic [CHAR_W-1:0] ch,
                                                    logic [COLOR_W-1:0] attr);
        return {attr, ch};
    endfunction

    // Moves the cursor to the start of the next row; past the last row the
    // grid shifts up one row and the bottom row is blanked in the current colour.
    function automatic void step_to_next_row();
        col_pos = 0;
        row_pos++;
        if (row_pos >= ROWS) begin
            row_pos = ROWS - 1;
            for (int i = 0; i + COLUMNS < CELLS; i++)
                screen_shadow[i] = screen_shadow[i + COLUMNS];
            for (int i = CELLS - COLUMNS; i < CELLS; i++)
                screen_shadow[i] = pack_cell(BLANK_CODE, text_attr);
        end
    endfunction

    // Applies one request to the shadow state and returns its result.
    function automatic t_result run_console_request(logic req,
                                                    logic [CHAR_W-1:0] ch,
                                                    logic [ROW_FIELD_W-1:0] rr,
                                                    logic [COL_FIELD_W-1:0] rc);
        t_result res;
        res.cell_data = '0;
        if (req == REQ_READ) begin
            if (rr < ROWS && rc < COLUMNS)
                res.cell_data = screen_shadow[rr * COLUMNS + rc];
        end else if (ch == NEWLINE_CODE) begin
            step_to_next_row();
        end else begin
            screen_shadow[row_pos * COLUMNS + col_pos] = pack_cell(ch, text_attr);
            col_pos++;
            if (col_pos >= COLUMNS)
                step_to_next_row();
        end
        res.cursor_row    = ROW_FIELD_W'(row_pos);
        res.cursor_column = COL_FIELD_W'(col_pos);
        return res;
    endfunction

    function automatic void compare_field(string field, int want, int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, field, want, got);
            error_count++;
        end
    endfunction

    // All three channels are sampled on the rising edge.
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            for (int i = 0; i < CELLS; i++)
                screen_shadow[i] = pack_cell(BLANK_CODE, RESET_COLOR);
            row_pos   = 0;
            col_pos   = 0;
            text_attr = RESET_COLOR;
            console_results_q.delete();
        end else begin
            // A result beat is matched against the oldest prediction.
            if (i_pop && !i_empty) begin
                if (console_results_q.size() == 0) begin
                    $display("%0t: result beat with no request waiting, actual cell 0x%0h row %0d column %0d",
                             $time, i_cell_data, i_cursor_row, i_cursor_column);
                    error_count++;
                end else begin
                    want = console_results_q.pop_front();
                    compare_field("cell_data", want.cell_data, i_cell_data);
                    compare_field("cursor_row", want.cursor_row, i_cursor_row);
                    compare_field("cursor_column", want.cursor_column, i_cursor_column);
                end
            end
            if (i_cfg_valid && i_cfg_ready)
                text_attr = i_cfg_data;
            // A request beat adds one prediction.
            if (i_push && !i_full)
                console_results_q.push_back(run_console_request(i_req_type, i_char_code,
                                                                i_read_row, i_read_column));
        end
        pending_count = console_results_q.size();
    end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Text console testbench
// Drives puts, newlines and cell reads into the text console with bursty
// request timing and a patterned result stall, steps the colour register
// through its extremes between phases, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_top;
    import tccs_pkg::*;

    localparam int ROWS         = 25;
    localparam int COLUMNS      = 80;
    localparam int HALF_PERIOD  = 5;
    localparam int RESET_CYCLES = 11;
    localparam int RANDOM_ITEMS = 1350;
    localparam int PHASES       = 4;
    localparam int DRAIN_CYCLES = 8;

    typedef enum logic [1:0] {
        POP_ALWAYS,
        POP_HALF,
        POP_SPARSE,
        POP_HOLD
    } t_pop_pattern;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   push          = 1'b0;
    logic                   full;
    logic                   req_type      = REQ_PUT;
    logic [CHAR_W-1:0]      char_code     = '0;
    logic [ROW_FIELD_W-1:0] read_row      = '0;
    logic [COL_FIELD_W-1:0] read_column   = '0;
    logic                   empty;
    logic                   pop           = 1'b0;
    logic [CELL_W-1:0]      cell_data;
    logic [ROW_FIELD_W-1:0] cursor_row;
    logic [COL_FIELD_W-1:0] cursor_column;
    logic                   cfg_valid     = 1'b0;
    logic                   cfg_ready;
    logic [COLOR_W-1:0]     cfg_data      = '0;

    int error_total;
    int pending_total;
    int burst_left    = 0;
    int sent_items    = 0;

    t_pop_pattern pop_pattern  = POP_ALWAYS;
    int           pattern_left = 0;

    always #HALF_PERIOD i_clk = ~i_clk;

    text_console_cursor_scroll #(
        .ROWS    (ROWS),
        .COLUMNS (COLUMNS)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_req_type      (req_type),
        .i_char_code     (char_code),
        .i_read_row      (read_row),
        .i_read_column   (read_column),
        .empty           (empty),
        .pop             (pop),
        .o_cell_data     (cell_data),
        .o_cursor_row    (cursor_row),
        .o_cursor_column (cursor_column),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data)
    );

    tb_console_checker #(
        .ROWS    (ROWS),
        .COLUMNS (COLUMNS)
    ) u_console_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (push),
        .i_full          (full),
        .i_req_type      (req_type),
        .i_char_code     (char_code),
        .i_read_row      (read_row),
        .i_read_column   (read_column),
        .i_empty         (empty),
        .i_pop           (pop),
        .i_cell_data     (cell_data),
        .i_cursor_row    (cursor_row),
        .i_cursor_column (cursor_column),
        .i_cfg_valid     (cfg_valid),
        .i_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data),
        .o_errors        (error_total),
        .o_pending       (pending_total)
    );

    // Presents one request beat from a falling edge and holds it until taken.
    // Beats go out in bursts of random length with random gaps between them.
    task automatic send_request(input logic kind, input logic [CHAR_W-1:0] ch,
                                input logic [ROW_FIELD_W-1:0] rr,
                                input logic [COL_FIELD_W-1:0] rc);
        if (burst_left == 0) begin
            push = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(1, 16);
        end
        burst_left--;
        push        = 1'b1;
        req_type    = kind;
        char_code   = ch;
        read_row    = rr;
        read_column = rc;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        @(negedge i_clk);
        sent_items++;
    endtask

    // A put carries random row and column fields, which the block ignores.
    task automatic put_char(input logic [CHAR_W-1:0] ch);
        send_request(REQ_PUT, ch, ROW_FIELD_W'($urandom_range(0, 31)),
                     COL_FIELD_W'($urandom_range(0, 127)));
    endtask

    // A read carries a random character field, which the block ignores.
    task automatic read_cell(input int rr, input int rc);
        send_request(REQ_READ, CHAR_W'($urandom_range(0, 255)),
                     ROW_FIELD_W'(rr), COL_FIELD_W'(rc));
    endtask

    // Stops sending and waits until every predicted result has arrived.
    task automatic wait_idle();
        push = 1'b0;
        while (pending_total != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // The result side stalls on its own changing pattern, long holds included.
    always @(negedge i_clk) begin
        if (pattern_left == 0) begin
            pop_pattern  = t_pop_pattern'($urandom_range(0, 3));
            pattern_left = $urandom_range(16, 96);
        end
        pattern_left--;
        case (pop_pattern)
            POP_ALWAYS: pop <= 1'b1;
            POP_HALF:   pop <= 1'($urandom_range(0, 1));
            POP_SPARSE: pop <= ($urandom_range(0, 3) == 0);
            default:    pop <= 1'b0;
        endcase
    end

    initial begin : stimulus
        logic [COLOR_W-1:0] phase_colors [PHASES];
        int                 phase_end;
        int                 pick;
        int                 run_len;
        int                 rr;

        phase_colors = '{8'h00, 8'hFF, COLOR_W'($urandom_range(1, 254)),
                         COLOR_W'($urandom_range(0, 255))};

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset fill at both corners, then reads past each edge and at the largest field values.
        read_cell(0, 0);
        read_cell(ROWS - 1, COLUMNS - 1);
        read_cell(ROWS, 0);
        read_cell(0, COLUMNS);
        read_cell(31, 127);
        // Extreme character codes, a newline, and read-back of what was put.
        put_char(8'h00);
        put_char(8'hFF);
        put_char(NEWLINE_CODE);
        put_char(8'h41);
        read_cell(0, 0);
        read_cell(0, 1);
        read_cell(1, 0);
        read_cell(1, 1);
        // Enough newlines to reach the last row and scroll from it.
        repeat (ROWS) put_char(NEWLINE_CODE);
        read_cell(ROWS - 1, 0);
        read_cell(ROWS - 2, 0);
        read_cell(0, 0);

        for (int phase = 0; phase < PHASES; phase++) begin
            // The colour register changes only while the block is idle.
            wait_idle();
            cfg_valid = 1'b1;
            cfg_data  = phase_colors[phase];
            @(posedge i_clk);
            while (!cfg_ready) @(posedge i_clk);
            @(negedge i_clk);
            cfg_valid = 1'b0;

            phase_end = sent_items + RANDOM_ITEMS / PHASES;
            while (sent_items < phase_end) begin
                pick = $urandom_range(0, 99);
                if (pick < 40) begin
                    // Short text with the odd newline and the odd raw byte.
                    run_len = $urandom_range(1, 12);
                    repeat (run_len) begin
                        case ($urandom_range(0, 7))
                            0:       put_char(NEWLINE_CODE);
                            1:       put_char(CHAR_W'($urandom_range(0, 255)));
                            default: put_char(CHAR_W'($urandom_range(32, 126)));
                        endcase
                    end
                end else if (pick < 47) begin
                    // A line long enough to wrap, often past the last row.
                    run_len = $urandom_range(COLUMNS - 20, COLUMNS + 20);
                    repeat (run_len) put_char(CHAR_W'($urandom_range(32, 126)));
                end else if (pick < 57) begin
                    repeat ($urandom_range(1, 4)) put_char(NEWLINE_CODE);
                end else if (pick < 85) begin
                    // Reads lean towards the bottom rows where the cursor sits.
                    repeat ($urandom_range(1, 6)) begin
                        rr = $urandom_range(0, 1) ? $urandom_range(ROWS - 2, ROWS - 1)
                                                  : $urandom_range(0, ROWS - 1);
                        read_cell(rr, $urandom_range(0, COLUMNS - 1));
                    end
                end else if (pick < 97) begin
                    // Raw field values, out-of-range reads among them.
                    if ($urandom_range(0, 1))
                        read_cell($urandom_range(0, 31), $urandom_range(0, 127));
                    else
                        put_char(CHAR_W'($urandom_range(0, 255)));
                end else begin
                    wait_idle();
                end
            end
        end

        wait_idle();
        if (error_total == 0 && pending_total == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Guard against a hung handshake.
    initial begin
        #8_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- files.f -----
hdl/tccs_pkg.sv
hdl/tccs_ram.sv
hdl/tccs_front.sv
hdl/tccs_cmd_queue.sv
hdl/tccs_back.sv
hdl/text_console_cursor_scroll.sv
tb/tb_console_checker.sv
tb/tb_top.sv
